/* design/ts_pid_continuity_checker_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the PID continuity checker
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TS_PID_CONTINUITY_CHECKER_UNIT_DEFINES_SVH
`define TS_PID_CONTINUITY_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define TSPCC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSPCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tspcc_pkg.sv */
// ----------------------------------------------------------------------------
// tspcc_pkg
// Widths, defaults and the queued word type of the PID continuity checker.
// ----------------------------------------------------------------------------
package tspcc_pkg;

	localparam int unsigned PID_W           = 13;
	localparam int unsigned CC_W            = 4;
	localparam int unsigned OUT_W           = 32;
	localparam int unsigned PID_ENTRIES_DEF = 8192;
	localparam int unsigned COUNT_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH     = 2;

	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [CC_W-1:0]  cc;
		logic             in_range;
	} item_t;

endpackage

/* design/tspcc_in_if.sv */
// ----------------------------------------------------------------------------
// tspcc_in_if
// Packet channel: PID and continuity counter with valid/ready.
// ----------------------------------------------------------------------------
interface tspcc_in_if;

	logic                         valid;
	logic                         ready;
	logic [tspcc_pkg::PID_W-1:0]  packet_pid;
	logic [tspcc_pkg::CC_W-1:0]   continuity_value;

	modport source (output valid, output packet_pid, output continuity_value, input ready);
	modport sink   (input valid, input packet_pid, input continuity_value, output ready);

endinterface

/* design/tspcc_out_if.sv */
// ----------------------------------------------------------------------------
// tspcc_out_if
// Result channel: per-packet continuity status with valid/ready.
// ----------------------------------------------------------------------------
interface tspcc_out_if;

	logic                         valid;
	logic                         ready;
	logic [tspcc_pkg::PID_W-1:0]  pid_echo;
	logic                         first_packet;
	logic [tspcc_pkg::CC_W-1:0]   gap_this_packet;
	logic [tspcc_pkg::OUT_W-1:0]  packet_total;
	logic [tspcc_pkg::OUT_W-1:0]  error_total;

	modport source (output valid, output pid_echo, output first_packet,
		output gap_this_packet, output packet_total, output error_total, input ready);
	modport sink   (input valid, input pid_echo, input first_packet,
		input gap_this_packet, input packet_total, input error_total, output ready);

endinterface

/* design/tspcc_front.sv */
// ----------------------------------------------------------------------------
// tspcc_front
// Accepts packet words, checks the PID against the table size, pushes them.
// ----------------------------------------------------------------------------
module tspcc_front #(
	parameter int unsigned PID_ENTRIES = tspcc_pkg::PID_ENTRIES_DEF
) (
	tspcc_in_if.sink           packet,
	input  logic               clearing,
	output logic               push_valid,
	input  logic               push_ready,
	output tspcc_pkg::item_t   push_item
);

	localparam int unsigned CMP_W = tspcc_pkg::PID_W + 1;

	assign packet.ready = push_ready && !clearing;
	assign push_valid   = packet.valid && !clearing;

	always_comb begin
		push_item.pid      = packet.packet_pid;
		push_item.cc       = packet.continuity_value;
		push_item.in_range = {1'b0, packet.packet_pid} < CMP_W'(PID_ENTRIES);
	end

endmodule

/* design/tspcc_queue.sv */
// ----------------------------------------------------------------------------
// tspcc_queue
// Short FIFO between the front and the table back end.
// ----------------------------------------------------------------------------
module tspcc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  tspcc_pkg::item_t   push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output tspcc_pkg::item_t   pop_item
);

	localparam int unsigned DEPTH = tspcc_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tspcc_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/tspcc_back.sv */
// ----------------------------------------------------------------------------
// tspcc_back
// Per-PID table: clearing sweep, read-modify-write and the result register.
// ----------------------------------------------------------------------------
`include "ts_pid_continuity_checker_unit_defines.svh"

module tspcc_back #(
	parameter int unsigned PID_ENTRIES = tspcc_pkg::PID_ENTRIES_DEF,
	parameter int unsigned COUNT_WIDTH = tspcc_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  tspcc_pkg::item_t   q_item,
	output logic               clearing,
	tspcc_out_if.source        result
);

	localparam int unsigned IDX_W = $clog2(PID_ENTRIES);
	localparam int unsigned CC_W  = tspcc_pkg::CC_W;
	localparam int unsigned OUT_W = tspcc_pkg::OUT_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_CALC  = 2'd2;

	typedef struct packed {
		logic                   seen;
		logic [CC_W-1:0]        last;
		logic [COUNT_WIDTH-1:0] pcnt;
		logic [COUNT_WIDTH-1:0] gsum;
	} entry_t;

	entry_t                mem [PID_ENTRIES];
	entry_t                rd_data_q;
	tspcc_pkg::item_t      item_q;
	logic [1:0]            state_q;
	logic [IDX_W-1:0]      clr_idx_q;

	logic                  res_valid_q;
	logic [tspcc_pkg::PID_W-1:0] res_pid_q;
	logic                  res_first_q;
	logic [CC_W-1:0]       res_gap_q;
	logic [OUT_W-1:0]      res_ptot_q;
	logic [OUT_W-1:0]      res_etot_q;

	logic                  calc_fire;
	logic                  rd_en;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	entry_t                mem_wdata;
	logic [CC_W-1:0]       gap;
	logic [COUNT_WIDTH:0]  p_sum;
	logic [COUNT_WIDTH:0]  g_sum;
	logic [COUNT_WIDTH-1:0] new_p;
	logic [COUNT_WIDTH-1:0] new_g;
	logic [OUT_W-1:0]      p_out;
	logic [OUT_W-1:0]      g_out;

	assign clearing  = state_q == ST_CLEAR;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign rd_en     = q_pop && q_item.in_range;
	assign calc_fire = (state_q == ST_CALC) && (!res_valid_q || result.ready);

	assign gap   = rd_data_q.seen ? (item_q.cc - rd_data_q.last - 1'b1) : '0;
	assign p_sum = {1'b0, rd_data_q.pcnt} + (COUNT_WIDTH + 1)'(1);
	assign g_sum = {1'b0, rd_data_q.gsum} + (COUNT_WIDTH + 1)'(gap);
	assign new_p = p_sum[COUNT_WIDTH] ? '1 : p_sum[COUNT_WIDTH-1:0];
	assign new_g = g_sum[COUNT_WIDTH] ? '1 : g_sum[COUNT_WIDTH-1:0];

	if (COUNT_WIDTH > OUT_W) begin : g_clip_wide
		assign p_out = (|new_p[COUNT_WIDTH-1:OUT_W]) ? '1 : new_p[OUT_W-1:0];
		assign g_out = (|new_g[COUNT_WIDTH-1:OUT_W]) ? '1 : new_g[OUT_W-1:0];
	end else begin : g_clip_narrow
		assign p_out = OUT_W'(new_p);
		assign g_out = OUT_W'(new_g);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = item_q.pid[IDX_W-1:0];
		mem_wdata.seen = 1'b1;
		mem_wdata.last = item_q.cc;
		mem_wdata.pcnt = new_p;
		mem_wdata.gsum = new_g;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else if (calc_fire && item_q.in_range) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[q_item.pid[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_idx_q == IDX_W'(PID_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (calc_fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (calc_fire) begin
			res_pid_q <= item_q.pid;
			if (item_q.in_range) begin
				res_first_q <= !rd_data_q.seen;
				res_gap_q   <= gap;
				res_ptot_q  <= p_out;
				res_etot_q  <= g_out;
			end else begin
				res_first_q <= 1'b0;
				res_gap_q   <= '0;
				res_ptot_q  <= '0;
				res_etot_q  <= '0;
			end
		end
	end

	assign result.valid           = res_valid_q;
	assign result.pid_echo        = res_pid_q;
	assign result.first_packet    = res_first_q;
	assign result.gap_this_packet = res_gap_q;
	assign result.packet_total    = res_ptot_q;
	assign result.error_total     = res_etot_q;

	`TSPCC_ASSERT(a_no_pop_in_clear, state_q == ST_CLEAR, !q_pop, "word taken during clear")
	`TSPCC_ASSERT_NEXT(a_calc_loads_result, calc_fire,
		res_valid_q && (state_q == ST_IDLE), "result not loaded after update")
	`TSPCC_ASSERT(a_first_has_no_gap, res_valid_q && res_first_q,
		(res_gap_q == '0) && (res_etot_q == '0), "first packet reports a gap")
	`TSPCC_ASSERT(a_write_only_in_range, mem_we && (state_q != ST_CLEAR),
		item_q.in_range, "table written for an out-of-range PID")

endmodule

/* design/ts_pid_continuity_checker_unit.sv */
// ----------------------------------------------------------------------------
// ts_pid_continuity_checker_unit
// Per-PID transport stream continuity counter check.
// ----------------------------------------------------------------------------
// Channels: packet (sink) carries packet_pid and continuity_value; result
// (source) carries pid_echo, first_packet, gap_this_packet, packet_total and
// error_total. A word moves when valid and ready are both high.
// Each packet word gives exactly one result word, in order.
// Path: a packet word is taken into the queue, then passes the table read
// (into the item and read-data registers) and the update into the result register.
// The back end takes no new word until the single-port table
// read-modify-write of the last word is done.
// Reset: the table is swept to zero one entry a cycle; packet.ready stays
// low until the sweep ends.
// When the receiver stalls the result word holds, the back end waits with the
// next update, and the two-entry queue keeps taking packet words until full.
// PIDs of PID_ENTRIES or above leave the table untouched and report zeros.
// ----------------------------------------------------------------------------
module ts_pid_continuity_checker_unit #(
	parameter int unsigned PID_ENTRIES = tspcc_pkg::PID_ENTRIES_DEF,
	parameter int unsigned COUNT_WIDTH = tspcc_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tspcc_in_if.sink     packet,
	tspcc_out_if.source  result
);

	logic              clearing;
	logic              push_valid;
	logic              push_ready;
	tspcc_pkg::item_t  push_item;
	logic              q_valid;
	logic              q_pop;
	tspcc_pkg::item_t  q_item;

	tspcc_front #(
		.PID_ENTRIES(PID_ENTRIES)
	) u_front (
		.packet    (packet),
		.clearing  (clearing),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	tspcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (q_valid),
		.pop_ready (q_pop),
		.pop_item  (q_item)
	);

	tspcc_back #(
		.PID_ENTRIES(PID_ENTRIES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.clearing(clearing),
		.result  (result)
	);

endmodule
